### src/usb_ep0_control_state_machine_core_macros.svh
// Assertion macros for the endpoint-zero control engine.
// No dependencies; included by modules that assert.
`ifndef USB_EP0_CONTROL_STATE_MACHINE_CORE_MACROS_SVH
`define USB_EP0_CONTROL_STATE_MACHINE_CORE_MACROS_SVH
`define EP0_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define EP0_ASSERT_NR(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

### src/usbep0_pkg.sv
// Types, codes and constants of the endpoint-zero control engine.
// No dependencies; used by all modules of the block.
package usbep0_pkg;
  localparam int MAX_EP0_PACKET = 64;

  typedef enum logic [2:0] {
    EV_BUS_RESET = 3'd0, EV_ENUM_DONE = 3'd1, EV_SUSPEND = 3'd2, EV_RESUME = 3'd3,
    EV_SETUP = 3'd4, EV_IN_DONE = 3'd5, EV_OUT_DONE = 3'd6, EV_APP_REPLY = 3'd7
  } event_t;

  localparam logic [4:0] ACT_NONE = 5'd0;
  localparam logic [4:0] ACT_BUS_RESET = 5'd1;
  localparam logic [4:0] ACT_ENUMERATED = 5'd2;
  localparam logic [4:0] ACT_SUSPEND = 5'd3;
  localparam logic [4:0] ACT_WAKEUP = 5'd4;
  localparam logic [4:0] ACT_UNCONFIGURED = 5'd5;
  localparam logic [4:0] ACT_CONFIGURED = 5'd6;
  localparam logic [4:0] ACT_SET_ADDRESS = 5'd7;
  localparam logic [4:0] ACT_CLASS_OUT = 5'd8;
  localparam logic [4:0] ACT_GET_DESC = 5'd16;
  localparam logic [4:0] ACT_STALL = 5'd17;
  localparam logic [4:0] ACT_SEND = 5'd18;
  localparam logic [4:0] ACT_ZLP = 5'd19;
  localparam logic [4:0] ACT_ARM_OUT = 5'd20;
  localparam logic [4:0] ACT_ERROR = 5'd21;
  localparam logic [4:0] ACT_DONE = 5'd22;

  localparam logic [1:0] DS_UNINIT = 2'd0;
  localparam logic [1:0] DS_DEFAULT = 2'd1;
  localparam logic [1:0] DS_ADDRESS = 2'd2;
  localparam logic [1:0] DS_CONFIGURED = 2'd3;

  localparam logic [2:0] PH_NONE = 3'd0;
  localparam logic [2:0] PH_OUT_WAIT = 3'd1;
  localparam logic [2:0] PH_OUT_STATUS = 3'd2;
  localparam logic [2:0] PH_IN_WAIT = 3'd3;
  localparam logic [2:0] PH_IN_DATA = 3'd4;
  localparam logic [2:0] PH_IN_STATUS = 3'd5;

  localparam logic [7:0] REQ_GET_STATUS = 8'd0;
  localparam logic [7:0] REQ_CLEAR_FEATURE = 8'd1;
  localparam logic [7:0] REQ_SET_FEATURE = 8'd3;
  localparam logic [7:0] REQ_SET_ADDRESS = 8'd5;
  localparam logic [7:0] REQ_GET_DESC = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIG = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIG = 8'd9;

  localparam logic [1:0] APP_ACK = 2'd0;
  localparam logic [1:0] APP_STALL = 2'd1;
  localparam logic [1:0] APP_SEND = 2'd2;

  localparam logic [1:0] SRC_APP = 2'd0;
  localparam logic [1:0] SRC_CONFIG = 2'd1;
  localparam logic [1:0] SRC_STATUS = 2'd2;

  localparam logic [0:0] CFG_SELF_PWR = 1'd0;
  localparam logic [0:0] CFG_MAX_CONFIG = 1'd1;

  typedef struct packed {
    logic [2:0] evt_code;
    logic [6:0] ep0_max_packet;
    logic [7:0] bm_request_type;
    logic [7:0] b_request;
    logic [15:0] w_value;
    logic [15:0] w_index;
    logic [15:0] w_length;
    logic [3:0] ep_num;
    logic [1:0] app_action;
    logic [15:0] app_length;
  } req_t;

  typedef struct packed {
    logic [4:0] action;
    logic [6:0] packet_len;
    logic [15:0] data_offset;
    logic [1:0] data_source;
    logic [15:0] status_word;
    logic [7:0] target_num;
    logic [6:0] device_address;
    logic [7:0] transfer_tag;
    logic last;
  } res_t;

  typedef struct packed {
    logic [1:0] device_state;
    logic suspended;
    logic [7:0] active_config;
    logic wakeup_enabled;
    logic [6:0] packet_size;
    logic [2:0] ctrl_phase;
    logic [15:0] in_remaining;
    logic [15:0] in_position;
    logic in_from_app;
    logic [7:0] generation;
  } ctx_t;

  typedef struct packed {
    logic [2:0] count;
    res_t [3:0] items;
  } batch_t;
endpackage

### src/usbep0_engine.sv
// Single-pass event decode: current context and one request in, next context
// and up to four results out. Depends on usbep0_pkg.
module usbep0_engine #(
  parameter int MaxPacket = usbep0_pkg::MAX_EP0_PACKET
) (
  input  usbep0_pkg::req_t   req,
  input  usbep0_pkg::ctx_t   ctx,
  input  logic               self_pwr,
  input  logic [7:0]         max_config_value,
  output usbep0_pkg::ctx_t   ctx_next,
  output usbep0_pkg::batch_t batch
);
  import usbep0_pkg::*;

  localparam logic [6:0] MaxPkt = 7'(MaxPacket);

  ctx_t c;
  res_t [3:0] items;
  logic [2:0] n;
  logic [6:0] p;
  logic [4:0] base;
  logic [1:0] kind;
  logic [4:0] recip;
  logic is_in, addressed;
  logic [7:0] cfg;
  logic [15:0] len;
  logic [15:0] seglen;

  function automatic res_t mk(input logic [4:0] a);
    res_t r;
    r = '0;
    r.action = a;
    return r;
  endfunction

  always_comb begin
    c = ctx;
    items = '0;
    n = '0;
    p = req.ep0_max_packet;
    is_in = req.bm_request_type[7];
    base = is_in ? 5'd12 : ACT_CLASS_OUT;
    kind = req.bm_request_type[6:5];
    recip = req.bm_request_type[4:0];
    addressed = 1'b0;
    cfg = req.w_value[7:0];
    len = '0;
    seglen = '0;
    case (req.evt_code)
      EV_BUS_RESET: begin
        items[n[1:0]] = mk(ACT_BUS_RESET); n = n + 3'd1;
      end
      EV_ENUM_DONE: begin
        if (p < 7'd8) p = 7'd8;
        if (p > MaxPkt) p = MaxPkt;
        if (c.ctrl_phase == PH_OUT_WAIT || c.ctrl_phase == PH_IN_WAIT ||
            (c.ctrl_phase == PH_IN_DATA && c.in_from_app)) begin
          items[n[1:0]] = mk(ACT_ERROR); n = n + 3'd1;
        end
        c = '0;
        c.device_state = DS_DEFAULT;
        c.packet_size = p;
        c.generation = ctx.generation + 8'd1;
        items[n[1:0]] = mk(ACT_ENUMERATED); n = n + 3'd1;
      end
      EV_SUSPEND: begin
        c.suspended = 1'b1;
        if (c.device_state != DS_UNINIT) begin
          items[n[1:0]] = mk(ACT_SUSPEND); n = n + 3'd1;
        end
      end
      EV_RESUME: begin
        if (c.suspended) begin
          c.suspended = 1'b0;
          if (c.device_state != DS_UNINIT) begin
            items[n[1:0]] = mk(ACT_WAKEUP); n = n + 3'd1;
          end
        end
      end
      EV_SETUP: begin
        if (c.device_state != DS_UNINIT) begin
          if (c.ctrl_phase != PH_NONE) begin
            if (c.ctrl_phase == PH_OUT_WAIT || c.ctrl_phase == PH_IN_WAIT ||
                (c.ctrl_phase == PH_IN_DATA && c.in_from_app)) begin
              items[n[1:0]] = mk(ACT_ERROR); n = n + 3'd1;
            end
            c.generation = c.generation + 8'd1;
            c.in_remaining = '0;
            c.in_position = '0;
            c.in_from_app = 1'b0;
          end
          if (is_in) begin
            c.ctrl_phase = PH_IN_WAIT;
            c.in_remaining = req.w_length;
            c.in_position = '0;
            c.in_from_app = 1'b0;
          end else begin
            c.ctrl_phase = PH_OUT_WAIT;
          end
          addressed = c.device_state == DS_ADDRESS || c.device_state == DS_CONFIGURED;
          if (req.bm_request_type == 8'h00) begin
            case (req.b_request)
              REQ_SET_ADDRESS: begin
                c.device_state = DS_ADDRESS;
                items[n[1:0]] = mk(ACT_SET_ADDRESS);
                items[n[1:0]].device_address = req.w_value[6:0];
                n = n + 3'd1;
                c.ctrl_phase = PH_OUT_STATUS;
                items[n[1:0]] = mk(ACT_ZLP); n = n + 3'd1;
              end
              REQ_SET_CONFIG: begin
                if (!addressed) begin
                  c.ctrl_phase = PH_NONE; c.in_remaining = '0; c.in_position = '0;
                  items[n[1:0]] = mk(ACT_STALL); n = n + 3'd1;
                end else if (cfg == c.active_config) begin
                  c.ctrl_phase = PH_OUT_STATUS;
                  items[n[1:0]] = mk(ACT_ZLP); n = n + 3'd1;
                end else if (cfg == 8'd0) begin
                  c.active_config = '0;
                  c.device_state = DS_ADDRESS;
                  items[n[1:0]] = mk(ACT_UNCONFIGURED); n = n + 3'd1;
                  c.ctrl_phase = PH_OUT_STATUS;
                  items[n[1:0]] = mk(ACT_ZLP); n = n + 3'd1;
                end else if (cfg <= max_config_value) begin
                  c.active_config = cfg;
                  c.device_state = DS_CONFIGURED;
                  items[n[1:0]] = mk(ACT_CONFIGURED);
                  items[n[1:0]].status_word = {8'd0, cfg};
                  n = n + 3'd1;
                  c.ctrl_phase = PH_OUT_STATUS;
                  items[n[1:0]] = mk(ACT_ZLP); n = n + 3'd1;
                end else begin
                  c.active_config = '0;
                  c.device_state = DS_ADDRESS;
                  c.ctrl_phase = PH_NONE; c.in_remaining = '0; c.in_position = '0;
                  items[n[1:0]] = mk(ACT_STALL); n = n + 3'd1;
                end
              end
              REQ_SET_FEATURE, REQ_CLEAR_FEATURE: begin
                if (!addressed || req.w_value != 16'd1) begin
                  c.ctrl_phase = PH_NONE; c.in_remaining = '0; c.in_position = '0;
                  items[n[1:0]] = mk(ACT_STALL); n = n + 3'd1;
                end else begin
                  c.wakeup_enabled = (req.b_request == REQ_SET_FEATURE);
                  c.ctrl_phase = PH_OUT_STATUS;
                  items[n[1:0]] = mk(ACT_ZLP); n = n + 3'd1;
                end
              end
              default: begin
                c.ctrl_phase = PH_NONE; c.in_remaining = '0; c.in_position = '0;
                items[n[1:0]] = mk(ACT_STALL); n = n + 3'd1;
              end
            endcase
          end else if (req.bm_request_type == 8'h80) begin
            case (req.b_request)
              REQ_GET_DESC: begin
                items[n[1:0]] = mk(ACT_GET_DESC);
                items[n[1:0]].target_num = req.w_index[7:0];
                n = n + 3'd1;
              end
              REQ_GET_CONFIG, REQ_GET_STATUS: begin
                len = (req.b_request == REQ_GET_CONFIG) ? 16'd1 : 16'd2;
                if (len < c.in_remaining) c.in_remaining = len;
                c.in_position = '0;
                c.in_from_app = 1'b0;
                c.ctrl_phase = PH_IN_DATA;
                if (c.in_remaining != '0) begin
                  items[n[1:0]] = mk(ACT_SEND);
                  items[n[1:0]].packet_len = c.in_remaining[6:0];
                  if (req.b_request == REQ_GET_CONFIG) begin
                    items[n[1:0]].data_source = SRC_CONFIG;
                    items[n[1:0]].status_word = {8'd0, c.active_config};
                  end else begin
                    items[n[1:0]].data_source = SRC_STATUS;
                    items[n[1:0]].status_word = {14'd0, c.wakeup_enabled, self_pwr};
                  end
                  n = n + 3'd1;
                  c.in_position = c.in_remaining;
                  c.in_remaining = '0;
                end else begin
                  c.ctrl_phase = PH_IN_STATUS;
                  items[n[1:0]] = mk(ACT_ARM_OUT); n = n + 3'd1;
                end
              end
              default: begin
                c.ctrl_phase = PH_NONE; c.in_remaining = '0; c.in_position = '0;
                items[n[1:0]] = mk(ACT_STALL); n = n + 3'd1;
              end
            endcase
          end else if (recip == 5'd0 && (kind == 2'd1 || kind == 2'd2)) begin
            items[n[1:0]] = mk(base + {3'd0, kind} - 5'd1); n = n + 3'd1;
          end else if (recip == 5'd1) begin
            items[n[1:0]] = mk(base + 5'd2);
            items[n[1:0]].target_num = req.w_index[7:0];
            n = n + 3'd1;
          end else if (recip == 5'd2) begin
            items[n[1:0]] = mk(base + 5'd3);
            items[n[1:0]].target_num = {4'd0, req.w_index[3:0]};
            n = n + 3'd1;
          end else begin
            c.ctrl_phase = PH_NONE; c.in_remaining = '0; c.in_position = '0;
            items[n[1:0]] = mk(ACT_STALL); n = n + 3'd1;
          end
        end
      end
      EV_IN_DONE, EV_APP_REPLY: begin
        if (req.evt_code == EV_APP_REPLY) begin
          if (req.app_action == APP_ACK && c.ctrl_phase == PH_OUT_WAIT) begin
            c.ctrl_phase = PH_OUT_STATUS;
            items[n[1:0]] = mk(ACT_ZLP); n = n + 3'd1;
          end else if (req.app_action == APP_STALL &&
                       (c.ctrl_phase == PH_OUT_WAIT || c.ctrl_phase == PH_IN_WAIT)) begin
            c.ctrl_phase = PH_NONE; c.in_remaining = '0; c.in_position = '0;
            items[n[1:0]] = mk(ACT_STALL); n = n + 3'd1;
          end else if (req.app_action == APP_SEND && c.ctrl_phase == PH_IN_WAIT) begin
            if (req.app_length < c.in_remaining) c.in_remaining = req.app_length;
            c.in_position = '0;
            c.in_from_app = 1'b1;
            c.ctrl_phase = PH_IN_DATA;
          end
        end else if (req.ep_num == 4'd0 && c.ctrl_phase == PH_OUT_STATUS) begin
          c.ctrl_phase = PH_NONE;
          items[n[1:0]] = mk(ACT_DONE); n = n + 3'd1;
        end else if (req.ep_num == 4'd0 && c.ctrl_phase == PH_IN_DATA) begin
          c.ctrl_phase = PH_IN_DATA;
        end else begin
          c.ctrl_phase = c.ctrl_phase;
        end
        if (c.ctrl_phase == PH_IN_DATA && ctx.ctrl_phase != PH_NONE &&
            ((req.evt_code == EV_APP_REPLY && req.app_action == APP_SEND &&
              ctx.ctrl_phase == PH_IN_WAIT) ||
             (req.evt_code == EV_IN_DONE && req.ep_num == 4'd0 &&
              ctx.ctrl_phase == PH_IN_DATA))) begin
          if (c.in_remaining != '0) begin
            seglen = (c.in_remaining < {9'd0, c.packet_size}) ? c.in_remaining
                                                              : {9'd0, c.packet_size};
            items[n[1:0]] = mk(ACT_SEND);
            items[n[1:0]].packet_len = seglen[6:0];
            items[n[1:0]].data_offset = c.in_position;
            items[n[1:0]].data_source = SRC_APP;
            n = n + 3'd1;
            c.in_position = c.in_position + seglen;
            c.in_remaining = c.in_remaining - seglen;
          end else begin
            c.ctrl_phase = PH_IN_STATUS;
            items[n[1:0]] = mk(ACT_ARM_OUT); n = n + 3'd1;
          end
        end
      end
      EV_OUT_DONE: begin
        if (req.ep_num == 4'd0 && c.ctrl_phase == PH_IN_STATUS) begin
          c.ctrl_phase = PH_NONE;
          items[n[1:0]] = mk(ACT_DONE); n = n + 3'd1;
        end
      end
      default: ;
    endcase
    if (n == 3'd0) begin
      items[0] = mk(ACT_NONE);
      n = 3'd1;
    end
    for (int k = 0; k < 4; k++) begin
      items[k[1:0]].transfer_tag = c.generation;
      items[k[1:0]].last = (3'(k) == n - 3'd1);
    end
    ctx_next = c;
    batch.count = n;
    batch.items = items;
  end
endmodule

### src/usb_ep0_control_state_machine_core.sv
// Top level of the endpoint-zero control engine: config registers, context,
// result buffer. Depends on usbep0_pkg, usbep0_engine and the macros header.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_ready | usbep0_pkg::req_t
//  res     | out       | res_valid/res_ready | usbep0_pkg::res_t
//  cfg     | in        | cfg_we              | cfg_index, cfg_data
//
// A request is decoded combinationally into a batch of 1..4 results held in a
// result buffer; results leave one per cycle while res_ready is high. The next
// request is taken in the cycle the last result of a batch leaves, or when the
// buffer is empty. Reset is synchronous; output stalls hold the buffer.
`include "usb_ep0_control_state_machine_core_macros.svh"
module usb_ep0_control_state_machine_core #(
  parameter int MaxEp0Packet = usbep0_pkg::MAX_EP0_PACKET
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  usbep0_pkg::req_t  req,
  output logic              res_valid,
  input  logic              res_ready,
  output usbep0_pkg::res_t  res,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [7:0]        cfg_data
);
  import usbep0_pkg::*;

  logic       self_pwr;
  logic [7:0] max_config_value;
  ctx_t       ctx, ctx_next;
  batch_t     batch;
  res_t [3:0] buf_items;
  logic [2:0] count;
  logic [1:0] head;
  logic       take, pop;

  usbep0_engine #(.MaxPacket(MaxEp0Packet)) u_engine (
    .req(req), .ctx(ctx), .self_pwr(self_pwr),
    .max_config_value(max_config_value), .ctx_next(ctx_next), .batch(batch)
  );

  assign res_valid = count != 3'd0;
  assign res = buf_items[head];
  assign pop = res_valid && res_ready;
  assign req_ready = (count == 3'd0) || (count == 3'd1 && res_ready);
  assign take = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      self_pwr <= 1'b0;
      max_config_value <= 8'd1;
      ctx <= '{packet_size: 7'(MaxEp0Packet), default: '0};
      count <= '0;
      head <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SELF_PWR: self_pwr <= cfg_data[0];
          CFG_MAX_CONFIG: max_config_value <= cfg_data;
          default: ;
        endcase
      end
      if (take) begin
        ctx <= ctx_next;
        count <= batch.count;
        head <= '0;
      end else if (pop) begin
        count <= count - 3'd1;
        head <= head + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) buf_items <= batch.items;
  end

  `EP0_ASSERT(a_count_range, count <= 3'd4, "result count out of range")
  `EP0_ASSERT(a_last_on_end, (res_valid && count == 3'd1) |-> res.last, "last flag missing")
  `EP0_ASSERT(a_not_last_early, (res_valid && count > 3'd1) |-> !res.last, "last flag early")
  `EP0_ASSERT_NR(a_reset_empty, rst |=> !res_valid, "results after reset")
endmodule

### tb/tb_usb_ep0_control_state_machine_core.sv
// Testbench for the endpoint-zero control engine: directed and random requests,
// checked against an in-bench predictor of the control state machine.
// Depends on usbep0_pkg and usb_ep0_control_state_machine_core.
`timescale 1ns / 1ps
module tb_usb_ep0_control_state_machine_core;
  import usbep0_pkg::*;

  class ep0_scoreboard;
    logic        self_pwr;
    logic [7:0]  max_config;
    logic [1:0]  dev_state;
    logic        suspended;
    logic [7:0]  active_config;
    logic        wakeup_en;
    logic [6:0]  pkt_size;
    logic [2:0]  phase;
    logic [15:0] in_left;
    logic [15:0] in_pos;
    logic        in_app;
    logic [7:0]  gen;
    res_t        batch[$];
    res_t        pending[$];
    int          errors;
    int          checked;
    int          requests;

    function new();
      self_pwr = 1'b0;
      max_config = 8'd1;
      dev_state = DS_UNINIT;
      suspended = 1'b0;
      active_config = 8'd0;
      wakeup_en = 1'b0;
      pkt_size = 7'(MAX_EP0_PACKET);
      phase = PH_NONE;
      in_left = 16'd0;
      in_pos = 16'd0;
      in_app = 1'b0;
      gen = 8'd0;
      errors = 0;
      checked = 0;
      requests = 0;
    endfunction

    function void push(logic [4:0] act, logic [15:0] word = 0, logic [7:0] tgt = 0,
                       logic [6:0] addr = 0);
      res_t r;
      r = '0;
      r.action = act;
      r.status_word = word;
      r.target_num = tgt;
      r.device_address = addr;
      if (batch.size() < 4) batch.push_back(r);
    endfunction

    function void abort_xfer();
      logic [2:0] old;
      old = phase;
      phase = PH_NONE;
      gen = gen + 8'd1;
      if (old == PH_OUT_WAIT || old == PH_IN_WAIT || (old == PH_IN_DATA && in_app))
        push(ACT_ERROR);
      in_left = 16'd0;
      in_pos = 16'd0;
      in_app = 1'b0;
    endfunction

    function void stall_ep0();
      phase = PH_NONE;
      in_left = 16'd0;
      in_pos = 16'd0;
      push(ACT_STALL);
    endfunction

    function void ack_out();
      phase = PH_OUT_STATUS;
      push(ACT_ZLP);
    endfunction

    function void send_next(logic [1:0] src, logic [15:0] word);
      logic [15:0] len;
      res_t r;
      if (in_left > 0) begin
        len = (in_left < {9'd0, pkt_size}) ? in_left : {9'd0, pkt_size};
        r = '0;
        r.action = ACT_SEND;
        r.packet_len = len[6:0];
        r.data_offset = in_pos;
        r.data_source = src;
        r.status_word = word;
        if (batch.size() < 4) batch.push_back(r);
        in_pos = in_pos + len;
        in_left = in_left - len;
      end else begin
        phase = PH_IN_STATUS;
        push(ACT_ARM_OUT);
      end
    endfunction

    function void start_in(logic [15:0] len, logic app, logic [1:0] src, logic [15:0] word);
      if (len < in_left) in_left = len;
      in_pos = 16'd0;
      in_app = app;
      phase = PH_IN_DATA;
      send_next(src, word);
    endfunction

    function bit addressed();
      return dev_state == DS_ADDRESS || dev_state == DS_CONFIGURED;
    endfunction

    function void std_out(logic [7:0] breq, logic [15:0] value);
      case (breq)
        REQ_SET_ADDRESS: begin
          dev_state = DS_ADDRESS;
          push(ACT_SET_ADDRESS, 16'd0, 8'd0, value[6:0]);
          ack_out();
        end
        REQ_SET_CONFIG: begin
          if (!addressed()) stall_ep0();
          else if (value[7:0] == active_config) ack_out();
          else if (value[7:0] == 0) begin
            active_config = 8'd0;
            dev_state = DS_ADDRESS;
            push(ACT_UNCONFIGURED);
            ack_out();
          end else if (value[7:0] <= max_config) begin
            active_config = value[7:0];
            dev_state = DS_CONFIGURED;
            push(ACT_CONFIGURED, {8'd0, value[7:0]});
            ack_out();
          end else begin
            active_config = 8'd0;
            dev_state = DS_ADDRESS;
            stall_ep0();
          end
        end
        REQ_SET_FEATURE: begin
          if (!addressed() || value != 1) stall_ep0();
          else begin
            wakeup_en = 1'b1;
            ack_out();
          end
        end
        REQ_CLEAR_FEATURE: begin
          if (!addressed() || value != 1) stall_ep0();
          else begin
            wakeup_en = 1'b0;
            ack_out();
          end
        end
        default: stall_ep0();
      endcase
    endfunction

    function void do_setup(req_t q);
      logic [4:0] recip;
      logic [1:0] kind;
      logic [4:0] base;
      recip = q.bm_request_type[4:0];
      kind = q.bm_request_type[6:5];
      base = q.bm_request_type[7] ? 5'd12 : ACT_CLASS_OUT;
      if (dev_state == DS_UNINIT) return;
      if (phase != PH_NONE) abort_xfer();
      if (q.bm_request_type[7]) begin
        phase = PH_IN_WAIT;
        in_left = q.w_length;
        in_pos = 16'd0;
        in_app = 1'b0;
      end else begin
        phase = PH_OUT_WAIT;
      end
      if (q.bm_request_type == 8'h00) std_out(q.b_request, q.w_value);
      else if (q.bm_request_type == 8'h80) begin
        if (q.b_request == REQ_GET_DESC) push(ACT_GET_DESC, 16'd0, q.w_index[7:0]);
        else if (q.b_request == REQ_GET_CONFIG)
          start_in(16'd1, 1'b0, SRC_CONFIG, {8'd0, active_config});
        else if (q.b_request == REQ_GET_STATUS)
          start_in(16'd2, 1'b0, SRC_STATUS, {14'd0, wakeup_en, self_pwr});
        else stall_ep0();
      end else if (recip == 0) begin
        if (kind == 1) push(base);
        else if (kind == 2) push(base + 5'd1);
        else stall_ep0();
      end else if (recip == 1) push(base + 5'd2, 16'd0, q.w_index[7:0]);
      else if (recip == 2) push(base + 5'd3, 16'd0, {4'd0, q.w_index[3:0]});
      else stall_ep0();
    endfunction

    function void note_request(req_t q);
      logic [6:0] p;
      batch.delete();
      requests++;
      case (q.evt_code)
        EV_BUS_RESET: push(ACT_BUS_RESET);
        EV_ENUM_DONE: begin
          dev_state = DS_DEFAULT;
          suspended = 1'b0;
          active_config = 8'd0;
          wakeup_en = 1'b0;
          p = q.ep0_max_packet;
          if (p < 8) p = 7'd8;
          if (p > MAX_EP0_PACKET) p = 7'(MAX_EP0_PACKET);
          pkt_size = p;
          abort_xfer();
          push(ACT_ENUMERATED);
        end
        EV_SUSPEND: begin
          suspended = 1'b1;
          if (dev_state != DS_UNINIT) push(ACT_SUSPEND);
        end
        EV_RESUME: if (suspended) begin
          suspended = 1'b0;
          if (dev_state != DS_UNINIT) push(ACT_WAKEUP);
        end
        EV_SETUP: do_setup(q);
        EV_IN_DONE: if (q.ep_num == 0) begin
          if (phase == PH_OUT_STATUS) begin
            phase = PH_NONE;
            push(ACT_DONE);
          end else if (phase == PH_IN_DATA) send_next(SRC_APP, 16'd0);
        end
        EV_OUT_DONE: if (q.ep_num == 0 && phase == PH_IN_STATUS) begin
          phase = PH_NONE;
          push(ACT_DONE);
        end
        default: begin
          if (q.app_action == APP_ACK && phase == PH_OUT_WAIT) ack_out();
          else if (q.app_action == APP_STALL && (phase == PH_OUT_WAIT || phase == PH_IN_WAIT))
            stall_ep0();
          else if (q.app_action == APP_SEND && phase == PH_IN_WAIT)
            start_in(q.app_length, 1'b1, SRC_APP, 16'd0);
        end
      endcase
      if (batch.size() == 0) push(ACT_NONE);
      foreach (batch[k]) begin
        batch[k].transfer_tag = gen;
        batch[k].last = (k == batch.size() - 1);
        pending.push_back(batch[k]);
      end
    endfunction

    function void check_result(res_t got);
      res_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("result with nothing expected: action %0d", got.action);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.action != e.action) begin
        $error("action: expected %0d, got %0d", e.action, got.action); errors++;
      end
      if (got.packet_len != e.packet_len) begin
        $error("packet_len: expected %0d, got %0d", e.packet_len, got.packet_len); errors++;
      end
      if (got.data_offset != e.data_offset) begin
        $error("data_offset: expected %0d, got %0d", e.data_offset, got.data_offset); errors++;
      end
      if (got.data_source != e.data_source) begin
        $error("data_source: expected %0d, got %0d", e.data_source, got.data_source); errors++;
      end
      if (got.status_word != e.status_word) begin
        $error("status_word: expected %0h, got %0h", e.status_word, got.status_word); errors++;
      end
      if (got.target_num != e.target_num) begin
        $error("target_num: expected %0d, got %0d", e.target_num, got.target_num); errors++;
      end
      if (got.device_address != e.device_address) begin
        $error("device_address: expected %0d, got %0d", e.device_address, got.device_address);
        errors++;
      end
      if (got.transfer_tag != e.transfer_tag) begin
        $error("transfer_tag: expected %0d, got %0d", e.transfer_tag, got.transfer_tag);
        errors++;
      end
      if (got.last != e.last) begin
        $error("last: expected %0d, got %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_ready;
  req_t req = '0;
  logic res_valid;
  logic res_ready = 0;
  res_t res;
  logic cfg_we = 0;
  logic [0:0] cfg_index = CFG_SELF_PWR;
  logic [7:0] cfg_data = 0;

  ep0_scoreboard sb = new();
  int cycles = 0;
  int hold_off = 0;

  usb_ep0_control_state_machine_core u_top (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && req_valid && req_ready) sb.note_request(req);
    if (!rst && res_valid && res_ready) sb.check_result(res);
  end

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // hold off on results at random, with one long stretch to fill the block
  initial begin
    int g;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off > 0) begin
        res_ready <= 0;
        hold_off--;
      end else begin
        g = gap_len();
        if (g == 0) begin
          res_ready <= 1;
        end else begin
          res_ready <= 0;
          repeat (g) @(negedge clk);
          res_ready <= 1;
        end
      end
      @(negedge clk);
    end
  end

  task automatic send_request(req_t q);
    int g;
    g = gap_len();
    if (g > 0) begin
      req_valid <= 0;
      repeat (g) @(negedge clk);
    end
    req_valid <= 1;
    req <= q;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [7:0] val);
    req_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_SELF_PWR) sb.self_pwr = val[0];
    else sb.max_config = val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function req_t mk_setup(logic [7:0] bm, logic [7:0] br, logic [15:0] v,
                          logic [15:0] ix, logic [15:0] ln);
    req_t q;
    q = '0;
    q.evt_code = EV_SETUP;
    q.bm_request_type = bm;
    q.b_request = br;
    q.w_value = v;
    q.w_index = ix;
    q.w_length = ln;
    return q;
  endfunction

  function req_t mk_event(event_t ev, logic [3:0] ep = 0, logic [1:0] act = 0,
                          logic [15:0] len = 0, logic [6:0] mps = 64);
    req_t q;
    q = '0;
    q.evt_code = ev;
    q.ep_num = ep;
    q.app_action = act;
    q.app_length = len;
    q.ep0_max_packet = mps;
    return q;
  endfunction

  function req_t rnd_setup();
    logic [7:0] bms[8];
    logic [7:0] reqs[8];
    bms = '{8'h00, 8'h80, 8'h21, 8'hA1, 8'h41, 8'h01, 8'h82, 8'h00};
    reqs = '{REQ_GET_STATUS, REQ_CLEAR_FEATURE, REQ_SET_FEATURE, REQ_SET_ADDRESS,
             REQ_GET_DESC, REQ_GET_CONFIG, REQ_SET_CONFIG, REQ_SET_CONFIG};
    if ($urandom_range(0, 7) == 0)
      return mk_setup(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom));
    return mk_setup(bms[$urandom_range(0, 7)], reqs[$urandom_range(0, 7)],
                    16'($urandom_range(0, 3)), 16'($urandom),
                    16'($urandom_range(0, 200)));
  endfunction

  function req_t rnd_request();
    req_t q;
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      q = {$urandom, $urandom, $urandom};
      q.evt_code = EV_ENUM_DONE;
      return q;
    end
    if (r < 35) return rnd_setup();
    if (r < 60) return mk_event(EV_IN_DONE, ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'd0);
    if (r < 70) return mk_event(EV_OUT_DONE, ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'd0);
    if (r < 90) begin
      q = mk_event(EV_APP_REPLY, 4'd0, 2'($urandom_range(0, 3)),
                   16'($urandom_range(0, 300)));
      if ($urandom_range(0, 15) == 0) q.app_length = 16'($urandom);
      return q;
    end
    q = {$urandom, $urandom, $urandom};
    q.evt_code = 3'($urandom_range(0, 3));
    return q;
  endfunction

  initial begin
    req_t q;
    repeat (12) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    send_request(mk_setup(8'h00, REQ_SET_ADDRESS, 16'd5, 0, 0));
    send_request(mk_event(EV_SUSPEND));
    send_request(mk_event(EV_RESUME));
    send_request(mk_event(EV_BUS_RESET));
    send_request(mk_event(EV_ENUM_DONE, 0, 0, 0, 7'd3));
    send_request(mk_event(EV_SUSPEND));
    send_request(mk_event(EV_RESUME));
    send_request(mk_setup(8'h80, REQ_GET_STATUS, 0, 0, 16'hFFFF));
    send_request(mk_event(EV_IN_DONE, 4'd0));
    send_request(mk_event(EV_IN_DONE, 4'd0));
    send_request(mk_event(EV_IN_DONE, 4'hF));
    send_request(mk_event(EV_OUT_DONE, 4'd0));
    send_request(mk_setup(8'h00, REQ_SET_ADDRESS, 16'hFFFF, 0, 0));
    send_request(mk_setup(8'h00, REQ_SET_CONFIG, 16'd1, 0, 0));
    send_request(mk_setup(8'h00, REQ_SET_FEATURE, 16'd2, 0, 0));
    send_request(mk_setup(8'h00, REQ_SET_FEATURE, 16'd1, 0, 0));
    send_request(mk_setup(8'h00, REQ_CLEAR_FEATURE, 16'd1, 0, 0));
    send_request(mk_setup(8'hA1, 8'hFE, 0, 16'hFFFF, 16'd300));
    send_request(mk_event(EV_APP_REPLY, 0, APP_SEND, 16'd200));
    send_request(mk_setup(8'h21, 8'h00, 0, 0, 0));
    send_request(mk_event(EV_APP_REPLY, 0, APP_STALL));
    send_request(mk_setup(8'h02, 8'h01, 0, 16'hFFFF, 0));
    send_request(mk_event(EV_APP_REPLY, 0, APP_ACK));
    send_request(mk_setup(8'h80, 8'hFF, 0, 0, 0));
    send_request(mk_setup(8'h7F, 8'h00, 0, 0, 0));
    send_request(mk_event(EV_APP_REPLY, 0, 2'd3));

    write_reg(CFG_SELF_PWR, 8'd1);
    write_reg(CFG_MAX_CONFIG, 8'd255);
    send_request(mk_event(EV_ENUM_DONE, 0, 0, 0, 7'd127));
    send_request(mk_setup(8'h00, REQ_SET_ADDRESS, 16'd9, 0, 0));
    send_request(mk_setup(8'h00, REQ_SET_CONFIG, 16'd255, 0, 0));
    send_request(mk_setup(8'h80, REQ_GET_CONFIG, 0, 0, 16'd1));

    hold_off = 300;
    for (int i = 0; i < 500; i++) begin
      if (i == 170) write_reg(CFG_MAX_CONFIG, 8'd0);
      if (i == 340) begin
        write_reg(CFG_SELF_PWR, 8'd0);
        write_reg(CFG_MAX_CONFIG, 8'($urandom_range(1, 4)));
      end
      q = rnd_request();
      send_request(q);
    end
    req_valid <= 0;

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Ran %0d requests and checked %0d results over config settings and IN splits.",
             sb.requests, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
